// File: hw/rtl/psfc_pkg.sv
package psfc_pkg;

   // Table depth and the width of the values that are tested and stored.
   localparam int MAX_PRIMES  = 64;
   localparam int VALUE_WIDTH = 16;

   // Field widths of the stream channels.
   localparam int CAND_WIDTH  = 16;
   localparam int PRIME_WIDTH = 16;

   // Derived widths: table index, fill count and remainder step counter.
   localparam int IDX_WIDTH   = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
   localparam int COUNT_WIDTH = $clog2(MAX_PRIMES + 1);
   localparam int STEP_WIDTH  = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

   // Status that the remainder unit reports to the sequencer.
   typedef struct packed {
      logic done;
      logic is_zero;
   } rem_status_type;

endpackage

// File: hw/rtl/psfc_rem_unit.sv
// Restoring remainder unit: one dividend bit is shifted in per cycle while
// busy, and done pulses in the cycle after the last step.
// A divisor of zero leaves the dividend itself as the remainder, which is zero
// only for a dividend of zero.
module psfc_rem_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [psfc_pkg::VALUE_WIDTH-1:0]     dividend,
   input  logic [psfc_pkg::VALUE_WIDTH-1:0]     divisor,
   output psfc_pkg::rem_status_type             status
);

   logic                                busy_ff;
   logic                                done_ff;
   logic [psfc_pkg::STEP_WIDTH-1:0]     step_ff;
   logic [psfc_pkg::VALUE_WIDTH-1:0]    shift_ff;
   logic [psfc_pkg::VALUE_WIDTH-1:0]    divisor_ff;
   logic [psfc_pkg::VALUE_WIDTH-1:0]    rem_ff;
   logic [psfc_pkg::VALUE_WIDTH:0]      trial;
   logic [psfc_pkg::VALUE_WIDTH-1:0]    rem_in;

   // One restoring step: bring down the next bit, subtract when it fits.
   always_comb begin
      trial = {rem_ff, shift_ff[psfc_pkg::VALUE_WIDTH-1]};
      if (trial >= {1'b0, divisor_ff}) begin
         rem_in = psfc_pkg::VALUE_WIDTH'(trial - {1'b0, divisor_ff});
      end else begin
         rem_in = psfc_pkg::VALUE_WIDTH'(trial);
      end
   end

   // Step sequencing and the datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff    <= 1'b1;
            step_ff    <= psfc_pkg::STEP_WIDTH'(psfc_pkg::VALUE_WIDTH - 1);
            shift_ff   <= dividend;
            divisor_ff <= divisor;
            rem_ff     <= '0;
         end else if (busy_ff) begin
            rem_ff   <= rem_in;
            shift_ff <= shift_ff << 1;
            if (step_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               step_ff <= step_ff - 1'b1;
            end
         end
      end
   end

   assign status.done    = done_ff;
   assign status.is_zero = (rem_ff == '0);

endmodule

// File: hw/rtl/prime_sieve_filter_chain_core.sv
// Streaming prime sieve. Candidates arrive on the req_ channel, normally
// ascending from 2; each is tested for divisibility against the primes kept
// in an internal table of MAX_PRIMES entries. A candidate that no stored
// prime divides is sent out on the rsp_ channel and appended to the table.
// When the table is already full the survivor is still sent, with the full
// flag in rsp_tuser set, and is not stored. A candidate that is divided
// produces no transfer. req_tlast marks the end of a stream: after that item
// is handled the table is emptied, so the next candidate always survives.
// Throughput: one item at a time. req_tready is high only while idle. For each
// stored prime tested, an item passes ST_READ (one table read), ST_START (one
// unit start) and ST_DIVIDE (VALUE_WIDTH remainder steps and the done pulse);
// the bit-serial remainder unit sets how long an item takes. After the last
// comparison a survivor waits in ST_EMIT until the output register is free.
// The result sits in an output register; a stalled receiver only holds the
// next survivor back, and the block takes new items while a result waits.
// Reset empties the table and drops any pending result; table contents need
// no clearing since only entries below the fill count are ever used.
module prime_sieve_filter_chain_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [psfc_pkg::CAND_WIDTH-1:0]    req_tdata,   // [15:0] candidate
   input  logic                               req_tlast,   // end_of_stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [psfc_pkg::PRIME_WIDTH-1:0]   rsp_tdata,   // [15:0] prime
   output logic                               rsp_tuser    // [0] table_full
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_START,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   state_type                              state_ff;
   logic [psfc_pkg::VALUE_WIDTH-1:0]       cand_ff;
   logic                                   eos_ff;
   logic [psfc_pkg::IDX_WIDTH-1:0]         idx_ff;
   logic [psfc_pkg::COUNT_WIDTH-1:0]       count_ff;
   logic                                   rsp_valid_ff;
   logic [psfc_pkg::PRIME_WIDTH-1:0]       rsp_data_ff;
   logic                                   rsp_full_ff;

   logic [psfc_pkg::VALUE_WIDTH-1:0]       table_mem [psfc_pkg::MAX_PRIMES];
   logic [psfc_pkg::VALUE_WIDTH-1:0]       rd_data_ff;

   logic                                   req_fire;
   logic                                   out_free;
   logic                                   emit_fire;
   logic                                   table_full;
   logic                                   last_entry;
   logic                                   tbl_wr_en;
   logic                                   rem_start;
   psfc_pkg::rem_status_type               rem_status;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign emit_fire  = (state_ff == ST_EMIT) && out_free;
   assign table_full = (count_ff == psfc_pkg::COUNT_WIDTH'(psfc_pkg::MAX_PRIMES));
   assign last_entry = ((psfc_pkg::COUNT_WIDTH'(idx_ff) + psfc_pkg::COUNT_WIDTH'(1))
                        == count_ff);
   assign tbl_wr_en  = emit_fire && !table_full;
   assign rem_start  = (state_ff == ST_START);

   // Prime table: one write port for the new survivor, one registered read.
   always_ff @(posedge clock) begin
      if (tbl_wr_en) begin
         table_mem[count_ff[psfc_pkg::IDX_WIDTH-1:0]] <= cand_ff;
      end
      rd_data_ff <= table_mem[idx_ff];
   end

   // Shared remainder unit, used once for each stored prime tested.
   psfc_rem_unit u_rem_unit (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (cand_ff),
      .divisor  (rd_data_ff),
      .status   (rem_status)
   );

   // Sequencer, fill count and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A new result in the same cycle takes the place of the one leaving.
         if (rsp_valid_ff && rsp_tready && !emit_fire) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  cand_ff <= psfc_pkg::VALUE_WIDTH'(req_tdata);
                  eos_ff  <= req_tlast;
                  idx_ff  <= '0;
                  if (count_ff == '0) begin
                     state_ff <= ST_EMIT;
                  end else begin
                     state_ff <= ST_READ;
                  end
               end
            end
            ST_READ: begin
               state_ff <= ST_START;
            end
            ST_START: begin
               state_ff <= ST_DIVIDE;
            end
            ST_DIVIDE: begin
               if (rem_status.done) begin
                  if (rem_status.is_zero) begin
                     // Divided by a stored prime: no transfer for this item.
                     if (eos_ff) begin
                        count_ff <= '0;
                     end
                     state_ff <= ST_IDLE;
                  end else if (last_entry) begin
                     state_ff <= ST_EMIT;
                  end else begin
                     idx_ff   <= idx_ff + 1'b1;
                     state_ff <= ST_READ;
                  end
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= psfc_pkg::PRIME_WIDTH'(cand_ff);
                  rsp_full_ff  <= table_full;
                  if (eos_ff) begin
                     count_ff <= '0;
                  end else if (!table_full) begin
                     count_ff <= count_ff + 1'b1;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_full_ff;

endmodule

// File: hw/rtl/psfc_checker.sv
// Port-level checks for the prime sieve.
module psfc_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [psfc_pkg::PRIME_WIDTH-1:0]   rsp_tdata,
   input  logic                               rsp_tuser
);

   // Leaving reset, the block is idle and holds no result.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (req_tready && !rsp_tvalid))
      else $error("block not idle after reset");

   // An accepted item keeps the block busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken again while an item is in work");

   // A new result only appears at the end of an item's work.
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result appeared while the block was idle");

   // A stalled result stays offered.
   a_rsp_valid_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("result withdrawn before transfer");

   // A stalled result keeps its payload.
   a_rsp_data_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> ($stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("result payload changed while stalled");

endmodule

bind prime_sieve_filter_chain_core psfc_checker u_psfc_checker (.*);
